/* rtl/wsfo_pkg.sv */
// package for wheel speed frame odometry: widths, codes, cordic angle table
// no dependencies
package wsfo_pkg;

   localparam int CordicStepsDef = 16;
   localparam int FracBitsDef    = 16;

   localparam logic [7:0]  CrcPoly      = 8'h8C;
   localparam logic [31:0] TickReset    = 32'd4295;
   localparam logic [30:0] InvTrkReset  = 31'd436180;
   localparam logic [34:0] CordicGain   = 35'd652032874;
   localparam logic [31:0] RadToBam     = 32'd683565276;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic CSR_TICK = 1'b0;
   localparam logic CSR_ITW  = 1'b1;

   typedef struct packed {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [15:0] heading;
      logic [31:0] lin_vel;
      logic [31:0] ang_vel;
   } pose_type;

   function automatic logic [31:0] atan_bam(input logic [4:0] i);
      case (i)
         5'd0:  atan_bam = 32'h20000000;  5'd1:  atan_bam = 32'h12E4051D;
         5'd2:  atan_bam = 32'h09FB385B;  5'd3:  atan_bam = 32'h051111D4;
         5'd4:  atan_bam = 32'h028B0D43;  5'd5:  atan_bam = 32'h0145D7E1;
         5'd6:  atan_bam = 32'h00A2F61E;  5'd7:  atan_bam = 32'h00517C55;
         5'd8:  atan_bam = 32'h0028BE53;  5'd9:  atan_bam = 32'h00145F2E;
         5'd10: atan_bam = 32'h000A2F98;  5'd11: atan_bam = 32'h000517CC;
         5'd12: atan_bam = 32'h00028BE6;  5'd13: atan_bam = 32'h000145F3;
         5'd14: atan_bam = 32'h0000A2F9;  5'd15: atan_bam = 32'h0000517C;
         5'd16: atan_bam = 32'h000028BE;  5'd17: atan_bam = 32'h0000145F;
         5'd18: atan_bam = 32'h00000A2F;  5'd19: atan_bam = 32'h00000517;
         5'd20: atan_bam = 32'h0000028B;  5'd21: atan_bam = 32'h00000145;
         5'd22: atan_bam = 32'h000000A2;  5'd23: atan_bam = 32'h00000051;
         default: atan_bam = 32'h0;
      endcase
   endfunction

   // 32-bit range saturation of a 66-bit signed value
   function automatic logic [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) sat32 = 32'h7FFFFFFF;
      else if (v < -66'sd2147483648) sat32 = 32'h80000000;
      else sat32 = v[31:0];
   endfunction

   // sign and magnitude (magnitude up to 2^32) to saturated 32-bit
   function automatic logic [31:0] signed_sat(input logic neg, input logic [63:0] mag);
      if (neg) signed_sat = (mag >= 64'h80000000) ? 32'h80000000 : 32'(-mag);
      else     signed_sat = (mag >= 64'h7FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
   endfunction

endpackage

/* rtl/wsfo_mul.sv */
// shift-add serial multiplier, 2 multiplier bits per cycle, unsigned
// depends on wsfo_pkg
module wsfo_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [31:0] b,
   output logic        done,
   output logic [95:0] prod
);
   import wsfo_pkg::*;

   logic [95:0] acc_ff, acc_in;
   logic [95:0] ash_ff, ash_in;
   logic [31:0] b_ff, b_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [95:0] part;

   always_comb begin
      part = (b_ff[0] ? ash_ff : 96'd0) + (b_ff[1] ? {ash_ff[94:0], 1'b0} : 96'd0);
      acc_in = acc_ff; ash_in = ash_ff; b_in = b_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      if (start) begin
         acc_in = 96'd0; ash_in = {32'd0, a}; b_in = b;
         cnt_in = 5'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = acc_ff + part;
         ash_in = {ash_ff[93:0], 2'b00};
         b_in = {2'b00, b_ff[31:2]};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= 5'd0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      acc_ff <= acc_in; ash_ff <= ash_in; b_ff <= b_in;
   end

   assign done = done_ff;
   assign prod = acc_ff;
endmodule

/* rtl/wsfo_cordic.sv */
// iterative cordic rotation, one micro-rotation per cycle
// depends on wsfo_pkg
module wsfo_cordic #(
   parameter int CORDIC_STEPS = wsfo_pkg::CordicStepsDef
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [15:0]        angle,
   output logic               done,
   output logic signed [34:0] cos_q30,
   output logic signed [34:0] sin_q30
);
   import wsfo_pkg::*;

   localparam int Steps = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;

   logic signed [34:0] x_ff, x_in, y_ff, y_in;
   logic signed [33:0] z_ff, z_in;
   logic [4:0] i_ff, i_in;
   logic busy_ff, busy_in, done_ff, done_in, flip_ff, flip_in;
   logic [31:0] zu;
   logic signed [34:0] xs, ys;

   always_comb begin
      zu = {angle, 16'd0};
      xs = x_ff >>> i_ff;
      ys = y_ff >>> i_ff;
      x_in = x_ff; y_in = y_ff; z_in = z_ff; i_in = i_ff;
      busy_in = busy_ff; done_in = 1'b0; flip_in = flip_ff;
      if (start) begin
         flip_in = zu[31] ^ zu[30];
         zu = zu + (flip_in ? 32'h80000000 : 32'd0);
         z_in = 34'(signed'(zu));
         x_in = CordicGain; y_in = 35'sd0; i_in = 5'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!z_ff[33]) begin
            x_in = x_ff - ys; y_in = y_ff + xs; z_in = z_ff - 34'(atan_bam(i_ff));
         end else begin
            x_in = x_ff + ys; y_in = y_ff - xs; z_in = z_ff + 34'(atan_bam(i_ff));
         end
         i_in = i_ff + 5'd1;
         if (i_ff == 5'(Steps - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      x_ff <= x_in; y_ff <= y_in; z_ff <= z_in; i_ff <= i_in; flip_ff <= flip_in;
   end

   assign done = done_ff;
   assign cos_q30 = flip_ff ? -x_ff : x_ff;
   assign sin_q30 = flip_ff ? -y_ff : y_ff;
endmodule

/* rtl/wheel_speed_frame_odometry.sv */
// top level: frame assembly with bit-serial crc, frame-end sequencer for pose update
// depends on wsfo_pkg, wsfo_mul, wsfo_cordic
//
// channel  dir  ports                    contents
// req      in   req_tvalid/tready/tdata  op (tuser), rx_byte (tdata 7:0)
// rsp      out  rsp_tvalid/tready/tdata  status (tuser), pose fields in tdata
// csr      in   csr_wen/addr/wdata       tick_seconds, inverse_track_width
//
// a byte is taken in idle, then its crc is shifted one bit per cycle; a tick bumps a saturating tick count
// a good check byte starts a sequence of six serial multiplies and one cordic rotation,
// followed by the output state;
// a bad one goes to the output state directly, with zero velocities
// req_tready is low outside idle; a finished frame waits until the output register is free
// synchronous reset clears position, heading, counters and control state
module wheel_speed_frame_odometry #(
   parameter int CORDIC_STEPS = wsfo_pkg::CordicStepsDef,
   parameter int FRAC_BITS    = wsfo_pkg::FracBitsDef
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // rx_byte
   input  logic         req_tuser,   // op
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // pos_x, pos_y, heading, lin_vel, ang_vel
   output logic         rsp_tuser,   // status
   input  logic         csr_wen,
   input  logic         csr_addr,
   input  logic [31:0]  csr_wdata
);
   import wsfo_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE = 10'b0000000001, S_CRC  = 10'b0000000010, S_DT   = 10'b0000000100,
      S_ANG  = 10'b0000001000, S_COR  = 10'b0000010000, S_MX   = 10'b0000100000,
      S_PX   = 10'b0001000000, S_HD   = 10'b0010000000, S_BAM  = 10'b0100000000,
      S_OUT  = 10'b1000000000
   } state_type;

   state_type st_ff, st_in;
   logic [31:0] tick_ff, tick_in;
   logic [30:0] itw_ff, itw_in;
   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [2:0]  bit_ff, bit_in;
   logic [63:0] frame_ff, frame_in;
   logic [31:0] px_ff, px_in, py_ff, py_in, lin_ff, lin_in, ang_ff, ang_in;
   logic [15:0] hd_ff, hd_in;
   logic [31:0] et_ff, et_in;
   logic [63:0] dt_ff, dt_in;
   logic [31:0] vx_ff, vx_in, vy_ff, vy_in;
   logic        sub_ff, sub_in;
   logic        st_bad_ff, st_bad_in;
   logic        ov_ff, ov_in;
   logic        vld_ff, vld_in;
   logic [143:0] out_ff, out_in;
   logic        outst_ff, outst_in;

   logic        m_start, m_done, c_start, c_done;
   logic [63:0] m_a;
   logic [31:0] m_b;
   logic [95:0] m_p;
   logic signed [34:0] c_cos, c_sin;

   wsfo_mul u_mul (.clock, .reset, .start(m_start), .a(m_a), .b(m_b),
                   .done(m_done), .prod(m_p));
   wsfo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cor (.clock, .reset, .start(c_start),
      .angle(hd_ff), .done(c_done), .cos_q30(c_cos), .sin_q30(c_sin));

   function automatic logic [31:0] f2fix(input logic [31:0] b);
      logic [7:0] e;
      logic [23:0] m;
      logic signed [10:0] s;
      logic [63:0] mag;
      e = b[30:23];
      m = {1'b0, b[22:0]};
      if (e == 8'hFF) begin
         if (m != 24'd0) return 32'd0;
         return b[31] ? 32'h80000000 : 32'h7FFFFFFF;
      end
      if (e == 8'd0) e = 8'd1; else m[23] = 1'b1;
      s = 11'(e) - 11'sd150 + 11'(FRAC_BITS);
      if (m == 24'd0) mag = 64'd0;
      else if (s >= 8) mag = 64'h100000000;
      else if (s >= 0) mag = 64'(m) << s[2:0];
      else if (-s >= 32) mag = 64'd0;
      else mag = 64'(m >> 5'(-s));
      return signed_sat(b[31], mag);
   endfunction

   // magnitude of a 32-bit signed value
   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? 32'(-v) : v;
   endfunction

   logic [31:0] lft, rgt;
   logic signed [33:0] diff, sum;
   logic [32:0] dmag;
   logic signed [67:0] vprod;
   logic [63:0] mdt;
   logic [31:0] mdt_res;
   logic [7:0] crc_x;

   always_comb begin
      lft = f2fix(frame_ff[31:0]);
      rgt = f2fix(frame_ff[63:32]);
      sum = 34'(signed'(lft)) + 34'(signed'(rgt));
      diff = 34'(signed'(rgt)) - 34'(signed'(lft));
      dmag = diff[33] ? 33'(-diff) : 33'(diff);
      // serial multiply result treated as v * dt (hi and lo terms in one pass)
      mdt = (m_p[95:64] != 32'd0) ? 64'h100000000 : {32'd0, m_p[63:32]};
      mdt_res = signed_sat(sub_ff, mdt);
      vprod = 68'(signed'(lin_ff)) * 68'(c_cos);
      crc_x = crc_ff[0] ? ((crc_ff >> 1) ^ CrcPoly) : (crc_ff >> 1);
   end

   always_comb begin
      st_in = st_ff; tick_in = tick_ff; itw_in = itw_ff; pos_in = pos_ff;
      crc_in = crc_ff; bit_in = bit_ff; frame_in = frame_ff;
      px_in = px_ff; py_in = py_ff; hd_in = hd_ff; lin_in = lin_ff; ang_in = ang_ff;
      et_in = et_ff; dt_in = dt_ff; vx_in = vx_ff; vy_in = vy_ff;
      sub_in = sub_ff; st_bad_in = st_bad_ff; ov_in = ov_ff;
      vld_in = vld_ff; out_in = out_ff; outst_in = outst_ff;
      m_start = 1'b0; m_a = 64'd0; m_b = 32'd0; c_start = 1'b0;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      if (csr_wen) begin
         if (csr_addr == CSR_TICK) tick_in = csr_wdata;
         else itw_in = csr_wdata[30:0];
      end
      unique case (st_ff)
         S_IDLE: if (req_tvalid && req_tready) begin
            if (req_tuser == OP_TICK) begin
               if (et_ff != 32'hFFFFFFFF) et_in = et_ff + 32'd1;
            end else if (pos_ff < 4'd8) begin
               frame_in = {req_tdata, frame_ff[63:8]};
               crc_in = crc_ff ^ req_tdata;
               bit_in = 3'd0; pos_in = pos_ff + 4'd1;
               st_in = S_CRC;
            end else begin
               pos_in = 4'd0; crc_in = 8'd0;
               if (crc_ff != req_tdata) begin
                  st_bad_in = 1'b1; lin_in = 32'd0; ang_in = 32'd0; st_in = S_OUT;
               end else begin
                  st_bad_in = 1'b0;
                  lin_in = sum[32:1];
                  m_start = 1'b1; m_a = {31'd0, dmag}; m_b = {1'b0, itw_ff};
                  sub_in = diff[33];
                  st_in = S_ANG;
               end
            end
         end
         S_CRC: begin
            crc_in = crc_x; bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) st_in = S_IDLE;
         end
         S_ANG: if (m_done) begin
            ang_in = signed_sat(sub_ff, {16'd0, m_p[63:16]} > 64'hFFFFFFFF ?
                                64'h100000000 : 64'(m_p[63:16]));
            m_start = 1'b1; m_a = {32'd0, et_ff}; m_b = tick_ff;
            st_in = S_DT;
         end
         S_DT: if (m_done) begin
            dt_in = m_p[63:0];
            c_start = 1'b1; st_in = S_COR;
         end
         S_COR: if (c_done) begin
            vx_in = sat32(66'(vprod >>> 30));
            vy_in = sat32(66'((68'(signed'(lin_ff)) * 68'(c_sin)) >>> 30));
            sub_in = vx_in[31];
            m_start = 1'b1; m_a = dt_ff; m_b = mag32(vx_in);
            ov_in = 1'b0; st_in = S_MX;
         end
         S_MX: if (m_done) begin
            if (!ov_ff) begin
               px_in = sat32(66'(signed'(px_ff)) + 66'(signed'(mdt_res)));
               sub_in = vy_ff[31];
               m_start = 1'b1; m_a = dt_ff; m_b = mag32(vy_ff);
               ov_in = 1'b1;
            end else begin
               py_in = sat32(66'(signed'(py_ff)) + 66'(signed'(mdt_res)));
               sub_in = ang_ff[31];
               m_start = 1'b1; m_a = dt_ff; m_b = mag32(ang_ff);
               st_in = S_HD;
            end
         end
         S_HD: if (m_done) begin
            sub_in = mdt_res[31];
            m_start = 1'b1; m_a = {32'd0, mag32(mdt_res)}; m_b = RadToBam;
            st_in = S_BAM;
         end
         S_BAM: if (m_done) begin
            hd_in = sub_ff ? 16'(hd_ff - 16'(m_p >> (FRAC_BITS + 16)))
                           : 16'(hd_ff + 16'(m_p >> (FRAC_BITS + 16)));
            et_in = 32'd0;
            st_in = S_OUT;
         end
         S_OUT: if (!vld_ff || rsp_tready) begin
            vld_in = 1'b1; outst_in = st_bad_ff;
            out_in = {ang_ff, lin_ff, hd_ff, py_ff, px_ff};
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   // control, position and heading state reset, datapath registers load freely
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; tick_ff <= TickReset; itw_ff <= InvTrkReset;
         pos_ff <= 4'd0; crc_ff <= 8'd0; px_ff <= 32'd0; py_ff <= 32'd0;
         hd_ff <= 16'd0; et_ff <= 32'd0; vld_ff <= 1'b0;
      end else begin
         st_ff <= st_in; tick_ff <= tick_in; itw_ff <= itw_in;
         pos_ff <= pos_in; crc_ff <= crc_in; px_ff <= px_in; py_ff <= py_in;
         hd_ff <= hd_in; et_ff <= et_in; vld_ff <= vld_in;
      end
      bit_ff <= bit_in; frame_ff <= frame_in; lin_ff <= lin_in; ang_ff <= ang_in;
      dt_ff <= dt_in; vx_ff <= vx_in; vy_ff <= vy_in;
      sub_ff <= sub_in; st_bad_ff <= st_bad_in; ov_ff <= ov_in;
      out_ff <= out_in; outst_ff <= outst_in;
   end

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = outst_ff;
endmodule
